// ===== src/bsm_pkg.sv =====
`default_nettype none
package bsm_pkg;

	localparam int COMP_W             = 16;
	localparam int ROW_W              = 10;
	localparam int SIDE_W             = 11;
	localparam int DEF_MAX_SIDE       = 1024;
	localparam int DEF_COMPONENT_BITS = 16;
	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(512);

	// Divide by multiplying with a rounded-up reciprocal, then shift right.
	// Exact for sums below 2**21.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;
	localparam int DIV_W       = 4;

	function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
		logic [RECIP_W-1:0] m;
		case (d)
			4'd2:    m = RECIP_W'(8388608);
			4'd3:    m = RECIP_W'(5592406);
			4'd4:    m = RECIP_W'(4194304);
			4'd6:    m = RECIP_W'(2796203);
			4'd9:    m = RECIP_W'(1864136);
			default: m = RECIP_W'(16777216);
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== src/bsm_in_if.sv =====
`default_nettype none
interface bsm_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsm_pkg::COMP_W-1:0] in_red;
	logic [bsm_pkg::COMP_W-1:0] in_green;
	logic [bsm_pkg::COMP_W-1:0] in_blue;

	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

// ===== src/bsm_out_if.sv =====
`default_nettype none
interface bsm_out_if;
	logic                       valid;
	logic                       ready;
	logic [bsm_pkg::COMP_W-1:0] out_red;
	logic [bsm_pkg::COMP_W-1:0] out_green;
	logic [bsm_pkg::COMP_W-1:0] out_blue;
	logic [bsm_pkg::ROW_W-1:0]  out_row;
	logic [bsm_pkg::ROW_W-1:0]  out_col;
	logic                       last_of_run;

	modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
		last_of_run, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
		last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/box_smooth_three_by_three_unit.sv =====
// 3x3 box mean over a raster stream of RGB pixels; at the edges only neighbors
// inside the image are averaged. Throughput: one item per cycle while the output
// register is free and the emit sequencer is idle; an item that causes several
// results (row ends and the last row) holds the input until the sequencer has
// issued them, one per cycle. Reset clears counters, window and pipeline valids;
// the line memories are not cleared, and entries not yet written are never summed.
`default_nettype none
module box_smooth_three_by_three_unit #(
	parameter int MAX_SIDE       = bsm_pkg::DEF_MAX_SIDE,
	parameter int COMPONENT_BITS = bsm_pkg::DEF_COMPONENT_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bsm_pkg::SIDE_W-1:0] cfg_wdata,
	bsm_in_if.sink                          pixels,
	bsm_out_if.source                       smoothed
);
	import bsm_pkg::*;

	localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;  // column/row counter
	localparam int EW   = CW + 1;                                  // effective side
	localparam int CB   = COMPONENT_BITS;
	localparam int PW   = 3 * CB;                                  // packed RGB
	localparam int RSW  = CB + 2;                                  // sum of three
	localparam int TSW  = CB + 4;                                  // sum of nine
	localparam int PRW  = TSW + RECIP_W;

	// ---------------------------------------------------------------- config
	logic [SIDE_W-1:0] side_q;
	logic [EW-1:0]     eff_side;
	logic [CW-1:0]     row_q, col_q;

	// Side of zero acts as one; clamp above the line memory depth.
	always_comb begin
		if (side_q == '0)
			eff_side = EW'(1);
		else if (32'(side_q) > 32'(MAX_SIDE))
			eff_side = EW'(MAX_SIDE);
		else
			eff_side = EW'(side_q);
	end

	// ---------------------------------------------------------------- control
	logic          en;         // whole pipeline moves when the output register frees
	logic          s2_take;    // sequencer takes the item sitting in stage 1
	logic          accept;
	logic [3:0]    s2_mask_q;  // results still to issue, raster order
	logic [3:0]    sel_one, rest_mask;

	assign en      = !smoothed.valid || smoothed.ready;
	assign s2_take = en && (rest_mask == '0);
	assign pixels.ready = s2_take;
	assign accept  = pixels.valid && pixels.ready;

	// ---------------------------------------------------------------- accept stage
	logic [CW-1:0] cur_r, cur_c;
	logic          r_last, c_last;
	logic [PW-1:0] px_in;

	always_comb begin
		cur_r  = (EW'(row_q) >= eff_side) ? '0 : row_q;
		cur_c  = (EW'(col_q) >= eff_side) ? '0 : col_q;
		r_last = EW'(cur_r) == eff_side - EW'(1);
		c_last = EW'(cur_c) == eff_side - EW'(1);
		px_in  = {pixels.in_blue[CB-1:0], pixels.in_green[CB-1:0], pixels.in_red[CB-1:0]};
	end

	// Line memories: middle holds the row one back, upper the row two back.
	// Middle is read and rewritten at accept (read returns the old entry).
	// Upper takes the old middle entry when the item leaves stage 1;
	// the next access to the same column comes no earlier.
	logic [PW-1:0] mid_mem [MAX_SIDE];
	logic [PW-1:0] up_mem  [MAX_SIDE];
	logic [PW-1:0] mid_rd_q, up_rd_q;

	// Stage 1 payload
	logic          s1_v;
	logic [PW-1:0] px_s1;
	logic [CW-1:0] r_s1, c_s1;
	logic [3:0]    mask_s1;
	logic          rge1_s1, rge2_s1, cge1_s1, cge2_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_q         <= mid_mem[cur_c];
			mid_mem[cur_c]   <= px_in;
			up_rd_q          <= up_mem[cur_c];
		end
		if (s2_take && s1_v)
			up_mem[c_s1] <= mid_rd_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px_in;
			r_s1    <= cur_r;
			c_s1    <= cur_c;
			rge1_s1 <= cur_r >= CW'(1);
			rge2_s1 <= cur_r >= CW'(2);
			cge1_s1 <= cur_c >= CW'(1);
			cge2_s1 <= cur_c >= CW'(2);
			// Bits 0 to 3 give (r-1,c-1), (r-1,c), (r,c-1), (r,c)
			mask_s1 <= {r_last && c_last,
				r_last && (cur_c >= CW'(1)),
				(cur_r >= CW'(1)) && c_last,
				(cur_r >= CW'(1)) && (cur_c >= CW'(1))};
		end
	end

	// ---------------------------------------------------------------- window + sequencer
	logic [PW-1:0] win_q [3][3];  // [row r-2..r][col c-2..c]
	logic [CW-1:0] r_s2, c_s2;
	logic          rge1_s2, rge2_s2, cge1_s2, cge2_s2;
	logic          dr, dc;
	logic [2:0]    rin, cin;

	always_comb begin
		sel_one   = s2_mask_q & (~s2_mask_q + 4'd1);
		rest_mask = s2_mask_q & ~sel_one;
		dr        = sel_one[0] | sel_one[1];
		dc        = sel_one[0] | sel_one[2];
		// Drop window rows and columns outside the image or the neighborhood.
		rin       = {1'b1, rge1_s2, rge2_s2 && dr};
		cin       = {1'b1, cge1_s2, cge2_s2 && dc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= SIDE_RESET;
			row_q     <= '0;
			col_q     <= '0;
			s1_v      <= 1'b0;
			s2_mask_q <= '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win_q[i][j] <= '0;
		end else begin
			if (cfg_we) begin
				side_q <= cfg_wdata;
				row_q  <= '0;
				col_q  <= '0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						win_q[i][j] <= '0;
			end else if (accept) begin
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : cur_r + CW'(1);
				end else begin
					col_q <= cur_c + CW'(1);
				end
			end
			if (s2_take) begin
				s1_v      <= accept;
				s2_mask_q <= s1_v ? mask_s1 : '0;
				if (s1_v && !cfg_we) begin
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= up_rd_q;
					win_q[1][2] <= mid_rd_q;
					win_q[2][2] <= px_s1;
				end
			end else if (en) begin
				s2_mask_q <= rest_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && s1_v) begin
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			rge1_s2 <= rge1_s1;
			rge2_s2 <= rge2_s1;
			cge1_s2 <= cge1_s1;
			cge2_s2 <= cge2_s1;
		end
	end

	// ---------------------------------------------------------------- emit pipeline
	// e1: masked row sums and divisor; e2: total and reciprocal; out: product.
	logic [RSW-1:0]   rsum [3][3];  // [row][channel]
	logic [1:0]       nr, nc;
	logic             e1_v, e2_v, out_v;
	logic [RSW-1:0]   e1_rsum [3][3];
	logic [DIV_W-1:0] e1_div;
	logic [CW-1:0]    e1_row, e1_col, e2_row, e2_col;
	logic             e1_last, e2_last;
	logic [TSW-1:0]   e2_tot [3];
	logic [RECIP_W-1:0] e2_m;
	logic [PRW-1:0]   prod [3];
	logic [CB-1:0]    q_q [3];
	logic [CW-1:0]    orow_q, ocol_q;
	logic             olast_q;

	always_comb begin
		nr = 2'(rin[0]) + 2'(rin[1]) + 2'(rin[2]);
		nc = 2'(cin[0]) + 2'(cin[1]) + 2'(cin[2]);
		for (int i = 0; i < 3; i++) begin
			for (int ch = 0; ch < 3; ch++) begin
				rsum[i][ch] = '0;
				for (int j = 0; j < 3; j++)
					if (rin[i] && cin[j])
						rsum[i][ch] = rsum[i][ch] + RSW'(win_q[i][j][ch*CB +: CB]);
			end
		end
		for (int ch = 0; ch < 3; ch++)
			prod[ch] = PRW'(e2_tot[ch]) * PRW'(e2_m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_v  <= 1'b0;
			e2_v  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			e1_v  <= s2_mask_q != '0;
			e2_v  <= e1_v;
			out_v <= e2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_rsum <= rsum;
			e1_div  <= DIV_W'(nr) * DIV_W'(nc);
			e1_row  <= r_s2 - CW'(dr);
			e1_col  <= c_s2 - CW'(dc);
			e1_last <= rest_mask == '0;

			for (int ch = 0; ch < 3; ch++)
				e2_tot[ch] <= TSW'(e1_rsum[0][ch]) + TSW'(e1_rsum[1][ch])
					+ TSW'(e1_rsum[2][ch]);
			e2_m    <= recip(e1_div);
			e2_row  <= e1_row;
			e2_col  <= e1_col;
			e2_last <= e1_last;

			for (int ch = 0; ch < 3; ch++)
				q_q[ch] <= prod[ch][RECIP_SHIFT +: CB];
			orow_q  <= e2_row;
			ocol_q  <= e2_col;
			olast_q <= e2_last;
		end
	end

	assign smoothed.valid       = out_v;
	assign smoothed.out_red     = COMP_W'(q_q[0]);
	assign smoothed.out_green   = COMP_W'(q_q[1]);
	assign smoothed.out_blue    = COMP_W'(q_q[2]);
	assign smoothed.out_row     = ROW_W'(orow_q);
	assign smoothed.out_col     = ROW_W'(ocol_q);
	assign smoothed.last_of_run = olast_q;

endmodule
`default_nettype wire
